FILE: rtl/frwl_pkg.sv
package frwl_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_BITS     = 16;
    localparam int DEF_COUNT_BITS  = 16;

    // fixed field widths on the ports
    localparam int ACTION_W  = 3;
    localparam int REQ_ID_W  = 16;
    localparam int STATUS_W  = 3;
    localparam int WRITER_W  = 16;
    localparam int READERS_W = 16;
    localparam int WAITING_W = 5;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [ACTION_W-1:0] {
        A_TRY_READ   = 3'd0,
        A_TRY_WRITE  = 3'd1,
        A_READ_LOCK  = 3'd2,
        A_WRITE_LOCK = 3'd3,
        A_UNLOCK     = 3'd4,
        A_DESTROY    = 3'd5,
        A_INIT       = 3'd6
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_BUSY     = 3'd1,
        ST_DEADLOCK = 3'd2,
        ST_QUEUED   = 3'd3,
        ST_FULL     = 3'd4,
        ST_NOT_HELD = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN
    } t_state;

    // control from the sequencer to the wait queue
    typedef struct packed {
        logic rd_en;
        logic push;
        logic pop;
        logic clear;
    } t_queue_cmd;

endpackage

FILE: rtl/frwl_queue.sv
module frwl_queue
    import frwl_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_W        = DEF_ID_BITS,
    localparam int IDX_W      = $clog2(QUEUE_DEPTH),
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_queue_cmd       i_cmd,
    input  logic [CNT_W-1:0] i_rd_off,
    input  logic [ID_W-1:0]  i_push_id,
    output logic [ID_W-1:0]  o_rd_id,
    output logic [CNT_W-1:0] o_count
);

    localparam int SUM_W = IDX_W + 1;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(QUEUE_DEPTH);

    logic [ID_W-1:0]  r_mem [QUEUE_DEPTH];
    logic [IDX_W-1:0] r_head;
    logic [CNT_W-1:0] r_count;
    logic [ID_W-1:0]  r_rd_id;

    logic [SUM_W-1:0] rd_sum;
    logic [SUM_W-1:0] wr_sum;
    logic [SUM_W-1:0] pop_sum;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] n_head;

    // ring index wrap: all sums stay below twice the depth
    always_comb begin
        rd_sum  = {1'b0, r_head} + SUM_W'(i_rd_off);
        wr_sum  = {1'b0, r_head} + SUM_W'(r_count);
        pop_sum = {1'b0, r_head} + SUM_W'(1);
        rd_addr = (rd_sum >= DEPTH_S) ? IDX_W'(rd_sum - DEPTH_S) : IDX_W'(rd_sum);
        wr_addr = (wr_sum >= DEPTH_S) ? IDX_W'(wr_sum - DEPTH_S) : IDX_W'(wr_sum);
        n_head  = (pop_sum >= DEPTH_S) ? IDX_W'(pop_sum - DEPTH_S) : IDX_W'(pop_sum);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[wr_addr] <= i_push_id;
        end
        if (i_cmd.rd_en) begin
            r_rd_id <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.push) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.pop) begin
            r_head  <= n_head;
            r_count <= r_count - CNT_W'(1);
        end
    end

    assign o_rd_id = r_rd_id;
    assign o_count = r_count;

endmodule

FILE: rtl/fifo_fair_reader_writer_lock_top.sv
// Channel   Dir  tdata (low bit up)                          tuser
// s         in   requester_id[15:0]                          action[2:0]
// m         out  status[2:0] writer_now[18:3]                -
//                readers_now[34:19] waiting_now[39:35]
//
// An item is accepted, then evaluated and its result loaded, when the waiting
// queue need not be searched. A blocking request that is refused scans the
// queue with one shared id comparator, one entry per cycle from the queue RAM.
// Synchronous active-low reset empties the lock; queue RAM contents are not
// cleared. Input is taken while a result still sits in the output register; a
// held result stalls only the next load.
module fifo_fair_reader_writer_lock_top
    import frwl_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS,
    parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [REQ_ID_W-1:0]   i_s_tdata,   // requester_id[15:0]
    input  logic [ACTION_W-1:0]   i_s_tuser,   // action[2:0]
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata    // status, writer_now, readers_now, waiting_now
);

    localparam int ID_W  = (ID_BITS < REQ_ID_W) ? ID_BITS : REQ_ID_W;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int RX_W  = (COUNT_BITS > READERS_W) ? COUNT_BITS : READERS_W;
    localparam int WX_W  = (CNT_W > WAITING_W) ? CNT_W : WAITING_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    t_state               r_state, n_state;
    t_action              r_action;
    logic [ID_W-1:0]      r_who;
    logic [ID_W-1:0]      r_writer, n_writer;
    logic [COUNT_BITS-1:0] r_readers, n_readers;
    logic [CNT_W-1:0]     r_idx;

    logic                 r_out_valid;
    t_status              r_out_status;
    logic [WRITER_W-1:0]  r_out_writer;
    logic [READERS_W-1:0] r_out_readers;
    logic [WAITING_W-1:0] r_out_waiting;

    t_queue_cmd           q_cmd;
    logic [CNT_W-1:0]     q_rd_off;
    logic [ID_W-1:0]      q_rd_id;
    logic [CNT_W-1:0]     q_count;
    logic [CNT_W-1:0]     n_count;

    logic                 s_accept;
    logic                 out_free;
    logic                 commit;

    // decision
    logic                 dec_done;
    logic                 dec_scan;
    t_status              dec_status;
    logic                 do_grant_rd, do_grant_wr, do_pop, do_push;
    logic                 do_unlock_w, do_unlock_r, do_init;
    logic                 id_match, head_ok, is_last, search;
    logic                 rd_ok;

    logic [RX_W-1:0]      readers_x;
    logic [WX_W-1:0]      count_x;

    assign s_accept = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;

    // shared comparator: queue entry under scan against the requester
    assign id_match = (q_rd_id == r_who);
    assign head_ok  = (q_count == '0) || id_match;
    assign is_last  = ((r_idx + CNT_W'(1)) == q_count);
    assign rd_ok    = (r_writer == '0) && head_ok && (r_readers != '1);

    always_comb begin
        dec_done    = 1'b0;
        dec_scan    = 1'b0;
        dec_status  = ST_BUSY;
        do_grant_rd = 1'b0;
        do_grant_wr = 1'b0;
        do_pop      = 1'b0;
        do_push     = 1'b0;
        do_unlock_w = 1'b0;
        do_unlock_r = 1'b0;
        do_init     = 1'b0;
        search      = 1'b0;

        if (r_state == S_EVAL) begin
            dec_done = 1'b1;
            if (r_who == '0 && r_action != A_DESTROY && r_action != A_INIT) begin
                dec_status = ST_BUSY;
            end else begin
                case (r_action)
                    A_TRY_READ, A_READ_LOCK: begin
                        if (rd_ok) begin
                            dec_status  = ST_OK;
                            do_grant_rd = 1'b1;
                            do_pop      = (q_count != '0);
                        end else if (r_action == A_READ_LOCK) begin
                            search = 1'b1;
                        end
                    end
                    A_TRY_WRITE, A_WRITE_LOCK: begin
                        if (r_readers == '0 && r_writer == r_who) begin
                            dec_status = ST_DEADLOCK;
                        end else if (r_readers == '0 && r_writer == '0 && head_ok) begin
                            dec_status  = ST_OK;
                            do_grant_wr = 1'b1;
                            do_pop      = (q_count != '0);
                        end else if (r_action == A_WRITE_LOCK) begin
                            search = 1'b1;
                        end
                    end
                    A_UNLOCK: begin
                        if (r_writer == r_who) begin
                            dec_status  = ST_OK;
                            do_unlock_w = 1'b1;
                        end else if (r_readers == '0) begin
                            dec_status = ST_NOT_HELD;
                        end else begin
                            dec_status  = ST_OK;
                            do_unlock_r = 1'b1;
                        end
                    end
                    A_DESTROY: begin
                        dec_status = (r_writer != '0 || q_count != '0) ? ST_BUSY : ST_OK;
                    end
                    A_INIT: begin
                        dec_status = ST_OK;
                        do_init    = 1'b1;
                    end
                    default: begin
                        dec_status = ST_BUSY;
                    end
                endcase
            end
        end else if (r_state == S_SCAN) begin
            dec_done = 1'b1;
            search   = 1'b1;
        end

        // queue membership step, then append when absent and the queue is not full
        if (search) begin
            if (q_count != '0 && id_match) begin
                dec_status = ST_DEADLOCK;
            end else if (q_count == '0 || is_last) begin
                if (q_count >= DEPTH_C) begin
                    dec_status = ST_FULL;
                end else begin
                    dec_status = ST_QUEUED;
                    do_push    = 1'b1;
                end
            end else begin
                dec_done = 1'b0;
                dec_scan = 1'b1;
            end
        end
    end

    assign commit = dec_done && out_free;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (commit) begin
                    n_state = S_IDLE;
                end else if (dec_scan) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_s_tready  = (r_state == S_IDLE);
        q_cmd.rd_en = (r_state == S_IDLE) || dec_scan;
        q_cmd.push  = commit && do_push;
        q_cmd.pop   = commit && do_pop;
        q_cmd.clear = commit && do_init;
        q_rd_off    = (r_state == S_IDLE) ? '0 : r_idx + CNT_W'(1);
    end

    // lock state after this item
    always_comb begin
        n_writer  = r_writer;
        n_readers = r_readers;
        n_count   = q_count;
        if (do_grant_rd) begin
            n_readers = r_readers + COUNT_BITS'(1);
        end
        if (do_grant_wr) begin
            n_writer = r_who;
        end
        if (do_unlock_w) begin
            n_writer = '0;
        end
        if (do_unlock_r) begin
            n_readers = r_readers - COUNT_BITS'(1);
        end
        if (do_pop) begin
            n_count = q_count - CNT_W'(1);
        end
        if (do_push) begin
            n_count = q_count + CNT_W'(1);
        end
        if (do_init) begin
            n_writer  = '0;
            n_readers = '0;
            n_count   = '0;
        end
        readers_x = RX_W'(n_readers);
        count_x   = WX_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_writer    <= '0;
            r_readers   <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_accept) begin
                r_idx <= '0;
            end else if (dec_scan) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (commit) begin
                r_writer    <= n_writer;
                r_readers   <= n_readers;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_action <= t_action'(i_s_tuser);
            r_who    <= i_s_tdata[ID_W-1:0];
        end
        if (commit) begin
            r_out_status  <= dec_status;
            r_out_writer  <= WRITER_W'(n_writer);
            r_out_readers <= readers_x[READERS_W-1:0];
            r_out_waiting <= count_x[WAITING_W-1:0];
        end
    end

    frwl_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_W        (ID_W)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (q_cmd),
        .i_rd_off  (q_rd_off),
        .i_push_id (r_who),
        .o_rd_id   (q_rd_id),
        .o_count   (q_count)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_waiting, r_out_readers, r_out_writer, r_out_status};

endmodule
